/* rtl/idfs_pkg.sv */
// ----------------------------------------------------------------------------
// idfs_pkg
// Shared types and codes for the ID allocator with a LIFO free stack.
// ----------------------------------------------------------------------------
package idfs_pkg;

    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int ID_W     = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_LOOKUP  = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // capture request, start memory reads
        logic execute;  // update state, load result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a new result
    } sts_t;

endpackage

/* rtl/id_allocator_free_stack.sv */
// Flow: an accepted request waits until the result register is free, then
// executes and loads the result register; the result waits for m_tready.
// Requests: no new request is accepted before the last one executes, set by
// the registered free stack and handle table reads ahead of the update.
// Reset: clears the state machine, valid bits, counters and result valid; the
// memories are not cleared and need no clearing pass. A clear request goes
// through the same accept and execute steps.
// ----------------------------------------------------------------------------
// id_allocator_free_stack
// Allocates IDs 1..MAX_IDS bound to caller handles, reusing freed IDs LIFO.
// ----------------------------------------------------------------------------
module id_allocator_free_stack #(
    parameter int MAX_IDS     = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] owner_handle, [22:16] target_id, [23] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [6:0] granted_id, [22:7] bound_handle, [23] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    idfs_pkg::cmd_t    cmd;
    idfs_pkg::sts_t    sts;
    idfs_pkg::status_t out_status;
    logic [idfs_pkg::ID_W-1:0]     out_granted;
    logic [idfs_pkg::HANDLE_W-1:0] out_bound;

    idfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    idfs_datapath #(
        .MAX_IDS     (MAX_IDS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (idfs_pkg::kind_t'(s_tuser)),
        .in_handle   (s_tdata[15:0]),
        .in_target   (s_tdata[22:16]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_granted (out_granted),
        .out_bound   (out_bound),
        .out_status  (out_status)
    );

    assign m_tdata = {1'b0, out_bound, out_granted};
    assign m_tuser = out_status;

endmodule

/* rtl/idfs_ctrl.sv */
// ----------------------------------------------------------------------------
// idfs_ctrl
// Request sequencer: accept a request, then execute it once the result
// register is free.
// ----------------------------------------------------------------------------
module idfs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  idfs_pkg::sts_t    sts,
    output idfs_pkg::cmd_t    cmd
);

    idfs_pkg::state_t state_reg;
    idfs_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idfs_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.accept  = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            idfs_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = idfs_pkg::S_EXEC;
                end
            end
            idfs_pkg::S_EXEC:
            begin
                // hold until the previous result is taken
                if (sts.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = idfs_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule

/* rtl/idfs_datapath.sv */
// ----------------------------------------------------------------------------
// idfs_datapath
// Free stack and handle table memories, valid bits, counters and the
// result register.
// ----------------------------------------------------------------------------
module idfs_datapath #(
    parameter int MAX_IDS     = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  idfs_pkg::cmd_t                    cmd,
    output idfs_pkg::sts_t                    sts,
    input  idfs_pkg::kind_t                   in_kind,
    input  logic [idfs_pkg::HANDLE_W-1:0]     in_handle,
    input  logic [idfs_pkg::ID_W-1:0]         in_target,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [idfs_pkg::ID_W-1:0]         out_granted,
    output logic [idfs_pkg::HANDLE_W-1:0]     out_bound,
    output idfs_pkg::status_t                 out_status
);

    localparam int CW = $clog2(MAX_IDS + 2);
    localparam int AW = $clog2(MAX_IDS);
    localparam int TW = (CW > idfs_pkg::ID_W) ? CW : idfs_pkg::ID_W;
    localparam int HW = (HANDLE_BITS < idfs_pkg::HANDLE_W) ? HANDLE_BITS : idfs_pkg::HANDLE_W;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_IDS);
    localparam logic [TW-1:0] MAX_T = TW'(MAX_IDS);

    // memories
    logic [CW-1:0] stack_mem [MAX_IDS];
    logic [HW-1:0] table_mem [MAX_IDS];
    logic [CW-1:0] stack_rd_reg;
    logic [HW-1:0] table_rd_reg;

    // request
    idfs_pkg::kind_t             kind_reg;
    logic [HW-1:0]               handle_reg;
    logic [idfs_pkg::ID_W-1:0]   target_reg;

    // allocator state
    logic [MAX_IDS-1:0] valid_reg, valid_next;
    logic [CW-1:0]      free_count_reg, free_count_next;
    logic [CW-1:0]      fresh_reg, fresh_next;
    logic [CW-1:0]      active_reg, active_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic [idfs_pkg::ID_W-1:0]     granted_reg;
    logic [idfs_pkg::HANDLE_W-1:0] bound_reg;
    idfs_pkg::status_t             status_reg;

    // execute stage
    logic [TW-1:0] in_tgt_ext, in_tgt_dec;
    logic [CW-1:0] fc_dec;
    logic [TW-1:0] tgt_ext, tgt_dec;
    logic [AW-1:0] tgt_idx;
    logic          tgt_reg_ok;
    logic [CW-1:0] id_sel, id_dec;
    logic [AW-1:0] id_idx;
    logic          id_ok;
    logic          id_found;
    logic [TW-1:0] granted_ext;
    logic [CW-1:0] granted_c;
    logic [idfs_pkg::HANDLE_W-1:0] bound_c;
    idfs_pkg::status_t status_c;
    logic          stack_we;
    logic          table_we;

    assign in_tgt_ext = TW'(in_target);
    assign in_tgt_dec = in_tgt_ext - TW'(1);
    assign fc_dec     = free_count_reg - CW'(1);

    assign tgt_ext    = TW'(target_reg);
    assign tgt_dec    = tgt_ext - TW'(1);
    assign tgt_idx    = tgt_dec[AW-1:0];
    assign tgt_reg_ok = (tgt_ext != '0) && (tgt_ext <= MAX_T) && valid_reg[tgt_idx];

    // pop the stack top, else take the next never-used ID
    always_comb
    begin
        id_found = 1'b1;
        if (free_count_reg != '0)
        begin
            id_sel = stack_rd_reg;
        end
        else if (fresh_reg != '0 && fresh_reg <= MAX_C)
        begin
            id_sel = fresh_reg;
        end
        else
        begin
            id_sel   = '0;
            id_found = 1'b0;
        end
    end

    assign id_dec = id_sel - CW'(1);
    assign id_idx = id_dec[AW-1:0];
    assign id_ok  = id_found && (id_sel != '0) && (id_sel <= MAX_C);

    always_comb
    begin
        valid_next      = valid_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        active_next     = active_reg;
        granted_c       = '0;
        bound_c         = '0;
        status_c        = idfs_pkg::ST_OK;
        stack_we        = 1'b0;
        table_we        = 1'b0;
        if (cmd.execute)
        begin
            unique case (kind_reg)
                idfs_pkg::KIND_ALLOC:
                begin
                    if (handle_reg == '0)
                    begin
                        status_c = idfs_pkg::ST_NULL;
                    end
                    else if (active_reg >= MAX_C)
                    begin
                        status_c = idfs_pkg::ST_FULL;
                    end
                    else
                    begin
                        if (free_count_reg != '0)
                        begin
                            free_count_next = fc_dec;
                        end
                        else if (id_found)
                        begin
                            fresh_next = fresh_reg + CW'(1);
                        end
                        if (!id_ok)
                        begin
                            status_c = idfs_pkg::ST_FULL;
                        end
                        else
                        begin
                            table_we  = 1'b1;
                            granted_c = id_sel;
                            if (!valid_reg[id_idx])
                            begin
                                valid_next[id_idx] = 1'b1;
                                active_next        = active_reg + CW'(1);
                            end
                        end
                    end
                end
                idfs_pkg::KIND_RELEASE:
                begin
                    if (!tgt_reg_ok)
                    begin
                        status_c = idfs_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        valid_next[tgt_idx] = 1'b0;
                        if (active_reg != '0)
                        begin
                            active_next = active_reg - CW'(1);
                        end
                        // drop the push if the stack is somehow full
                        if (free_count_reg < MAX_C)
                        begin
                            stack_we        = 1'b1;
                            free_count_next = free_count_reg + CW'(1);
                        end
                    end
                end
                idfs_pkg::KIND_LOOKUP:
                begin
                    if (!tgt_reg_ok)
                    begin
                        status_c = idfs_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        bound_c = idfs_pkg::HANDLE_W'(table_rd_reg);
                    end
                end
                idfs_pkg::KIND_CLEAR:
                begin
                    valid_next      = '0;
                    free_count_next = '0;
                    fresh_next      = CW'(1);
                    active_next     = '0;
                end
            endcase
        end
    end

    assign granted_ext = TW'(granted_c);

    // memories: read on accept, write on execute
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            stack_rd_reg <= stack_mem[fc_dec[AW-1:0]];
            table_rd_reg <= table_mem[in_tgt_dec[AW-1:0]];
        end
        if (stack_we)
        begin
            stack_mem[free_count_reg[AW-1:0]] <= tgt_ext[CW-1:0];
        end
        if (table_we)
        begin
            table_mem[id_idx] <= handle_reg;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= in_kind;
            handle_reg <= in_handle[HW-1:0];
            target_reg <= in_target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            free_count_reg <= '0;
            fresh_reg      <= CW'(1);
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            granted_reg <= granted_ext[idfs_pkg::ID_W-1:0];
            bound_reg   <= bound_c;
            status_reg  <= status_c;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_granted  = granted_reg;
    assign out_bound    = bound_reg;
    assign out_status   = status_reg;

endmodule
